// ===== src/at_final_result_recognizer_macros.svh =====
// Assertion helpers for afr_frame_ctrl; they need clk and rst in scope.
`ifndef AT_FINAL_RESULT_RECOGNIZER_MACROS_SVH
`define AT_FINAL_RESULT_RECOGNIZER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define AFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define AFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/afr_pkg.sv =====
package afr_pkg;

  localparam int KW_COUNT = 4;
  localparam int KW_MAX   = 7;

  // Keyword slots
  localparam int KW_OK      = 0;
  localparam int KW_ERROR   = 1;
  localparam int KW_FAIL    = 2;
  localparam int KW_CONNECT = 3;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_O  = 8'h4F;

  // Keyword text, left aligned, zero padded
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
    '{8'h4F, 8'h4B, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // OK
    '{8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h00, 8'h00},  // ERROR
    '{8'h46, 8'h41, 8'h49, 8'h4C, 8'h00, 8'h00, 8'h00},  // FAIL
    '{8'h43, 8'h4F, 8'h4E, 8'h4E, 8'h45, 8'h43, 8'h54}   // CONNECT
  };

  localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd5, 3'd4, 3'd7};

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd1,
    PH_LINE    = 3'd2,
    PH_INFO_CR = 3'd3,
    PH_INFO_LF = 3'd4,
    PH_FINAL   = 3'd5
  } afr_phase_t;

  // Link between neighboring matcher cells
  typedef struct packed {
    logic [7:0]          data;
    logic                search;
    logic [KW_COUNT-1:0] found;
  } afr_link_t;

  typedef struct packed {
    logic status;
    logic connect;
  } afr_result_t;

  // Longest keyword prefix that ends the matched prefix of length p_in plus c.
  function automatic logic [2:0] kw_step(input int w, input logic [2:0] p_in,
                                         input logic [7:0] c);
    logic [3:0] p;
    logic [3:0] res;
    logic       hit_k;
    logic       done;
    p    = (p_in >= KW_LEN[w]) ? 4'd0 : {1'b0, p_in};
    res  = 4'd0;
    done = 1'b0;
    for (int k = KW_MAX; k >= 1; k--) begin
      if (!done && (k <= int'(p) + 1)) begin
        hit_k = (KW_TEXT[w][k-1] == c);
        for (int i = 0; i < k - 1; i++) begin
          if (KW_TEXT[w][i] != KW_TEXT[w][int'(p) - (k - 1) + i]) begin
            hit_k = 1'b0;
          end
        end
        if (hit_k) begin
          res  = 4'(k);
          done = 1'b1;
        end
      end
    end
    return res[2:0];
  endfunction

endpackage

// ===== src/afr_match_cell.sv =====
module afr_match_cell
  import afr_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      clear,
  input  afr_link_t link_in,
  output afr_link_t link_out
);

  logic [2:0] progress;
  logic       found;
  logic [2:0] step;
  logic       hit;
  logic [2:0] progress_next;
  logic       found_next;

  assign step = kw_step(IDX, progress, link_in.data);
  assign hit  = (step >= KW_LEN[IDX]);

  always_comb begin
    progress_next = progress;
    found_next    = found;
    if (link_in.search) begin
      progress_next = hit ? 3'd0 : step;
      found_next    = found | hit;
    end
  end

  // Found bit after this byte's search, before any clear
  always_comb begin
    link_out          = link_in;
    link_out.found[IDX] = found_next;
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      progress <= 3'd0;
      found    <= 1'b0;
    end else begin
      progress <= progress_next;
      found    <= found_next;
    end
  end

endmodule

// ===== src/afr_frame_ctrl.sv =====
module afr_frame_ctrl
  import afr_pkg::*;
#(
  parameter int BUF_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  logic [7:0]          data,
  input  logic [KW_COUNT-1:0] found,
  output logic                search,
  output logic                clear,
  output logic                res_valid,
  output afr_result_t         res
);

`include "at_final_result_recognizer_macros.svh"

  localparam int CNT_W = $clog2(BUF_DEPTH + 1);

  afr_phase_t       phase;
  afr_phase_t       phase_next;
  logic [CNT_W-1:0] count;
  logic [7:0]       prev;
  logic             empty;
  logic             crlf;
  logic             any_fail;

  assign empty    = (count == '0);
  assign crlf     = !empty && (prev == CH_CR) && (data == CH_LF);
  assign any_fail = found[KW_ERROR] | found[KW_FAIL];
  assign search   = fire && (count < CNT_W'(BUF_DEPTH));

  always_comb begin
    phase_next = phase;
    if (fire) begin
      case (phase)
        PH_LINE: begin
          if (crlf) begin
            phase_next = (found[KW_OK] || any_fail) ? PH_LEAD : PH_INFO_CR;
          end
        end
        PH_INFO_CR: begin
          if (data == CH_CR) begin
            phase_next = PH_INFO_LF;
          end else if (data == CH_O) begin
            phase_next = PH_FINAL;
          end else begin
            phase_next = PH_LEAD;
          end
        end
        PH_INFO_LF: begin
          phase_next = (data == CH_LF) ? PH_FINAL : PH_LEAD;
        end
        PH_FINAL: begin
          if (crlf) begin
            phase_next = PH_LEAD;
          end
        end
        default: begin
          phase_next = (!empty && (data == CH_LF)) ? PH_LINE : PH_LEAD;
        end
      endcase
    end
  end

  always_comb begin
    res_valid   = 1'b0;
    res.status  = 1'b1;
    res.connect = 1'b0;
    clear       = 1'b0;
    if (fire) begin
      case (phase)
        PH_LINE: begin
          if (crlf && found[KW_OK]) begin
            res_valid   = 1'b1;
            res.status  = 1'b0;
            res.connect = found[KW_CONNECT];
          end else if (crlf && any_fail) begin
            res_valid = 1'b1;
          end
        end
        PH_INFO_CR: begin
          res_valid = (data != CH_CR) && (data != CH_O);
        end
        PH_INFO_LF: begin
          res_valid = (data != CH_LF);
        end
        PH_FINAL: begin
          if (crlf) begin
            res_valid   = 1'b1;
            res.status  = !found[KW_OK];
            res.connect = found[KW_OK] & found[KW_CONNECT];
          end
        end
        default: begin
          if (empty) begin
            clear = (data != CH_CR);
          end else begin
            res_valid = (data != CH_LF);
          end
        end
      endcase
      clear = clear | res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      count <= '0;
      prev  <= 8'h00;
    end else begin
      phase <= phase_next;
      if (fire) begin
        prev <= data;
      end
      if (clear) begin
        count <= '0;
      end else if (search) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  `AFR_ASSERT_NEXT(a_result_empties, res_valid, (count == '0) && (phase == PH_LEAD), "result did not empty the collection")
  `AFR_ASSERT_NOW(a_err_no_connect, res_valid && res.status, !res.connect, "connect flag on an error result")
  `AFR_ASSERT_NOW(a_count_bound, 1'b1, count <= CNT_W'(BUF_DEPTH), "byte count past buffer depth")
  `AFR_ASSERT_NOW(a_framed_count, phase != PH_LEAD, count >= CNT_W'(2), "framing past lead with short collection")

endmodule

// ===== src/afr_out_queue.sv =====
module afr_out_queue
  import afr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  afr_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output afr_result_t head
);

  logic [1:0]  fill;
  afr_result_t tail;
  logic        pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (fill != 2'd0);
  assign full      = (fill == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head <= full ? tail : push_data;
    end else if (push && (fill == 2'd0)) begin
      head <= push_data;
    end
    if (push && (fill == 2'd1) && !pop) begin
      tail <= push_data;
    end
  end

endmodule

// ===== src/at_final_result_recognizer.sv =====
// Channel | handshake              | payload
// --------+------------------------+-----------------------------
// in      | in_valid / in_stall    | rx_byte[7:0]
// out     | out_valid / out_stall  | final_status, connect_seen
//
// One byte per cycle while in_stall is low. A byte is parsed in the cycle
// of its transfer; its result, if any, is on the out channel the following
// cycle unless an earlier result waits. A two-entry result queue decouples
// the sides; in_stall rises only while both entries hold results that the
// receiver has not taken. Reset (rst, synchronous) returns the framing to
// the leading CR and empties the collection, matchers and result queue.
module at_final_result_recognizer
  import afr_pkg::*;
#(
  parameter int BUF_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       final_status,
  output logic       connect_seen
);

  afr_link_t   link [KW_COUNT+1];
  logic        fire;
  logic        search;
  logic        clear;
  logic        res_valid;
  afr_result_t res;
  afr_result_t head;
  logic        full;

  // Zero bytes are transferred but otherwise dropped.
  assign fire     = in_valid && !in_stall && (rx_byte != 8'h00);
  assign in_stall = full;

  // Row of keyword matchers: the byte and search strobe ride down the row,
  // each cell adding its found flag as it passes.
  assign link[0] = '{data: rx_byte, search: search, found: '0};

  for (genvar g = 0; g < KW_COUNT; g++) begin : g_cell
    afr_match_cell #(
      .IDX(g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .clear   (clear),
      .link_in (link[g]),
      .link_out(link[g+1])
    );
  end

  // Framing machine, byte count and result decision
  afr_frame_ctrl #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .data     (rx_byte),
    .found    (link[KW_COUNT].found),
    .search   (search),
    .clear    (clear),
    .res_valid(res_valid),
    .res      (res)
  );

  afr_out_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .full     (full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .head     (head)
  );

  assign final_status = head.status;
  assign connect_seen = head.connect;

endmodule

// ===== tb/at_final_result_recognizer_tb.sv =====
module at_final_result_recognizer_tb
  import afr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_DEPTH      = 256;
  localparam int BYTE_TARGET    = 1400;  // nonzero bytes, directed part included
  localparam int HOLD_CYCLES    = 60;    // long receiver hold-off
  localparam int SETTLE_CYCLES  = 8;     // quiet time after the last result is taken
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int PRINT_CAP      = 50;

  logic       clk;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       final_status;
  logic       connect_seen;

  at_final_result_recognizer #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .final_status(final_status),
    .connect_seen(connect_seen)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared run state
  // ---------------------------------------------------------------------------
  afr_result_t expected_results[$];  // results owed by the block, oldest first
  logic [7:0]  pending_bytes[$];     // response text waiting to be sent

  int  error_count     = 0;
  int  bytes_sent      = 0;  // nonzero bytes transferred
  int  zeros_sent      = 0;  // ignored bytes transferred
  int  ok_results      = 0;
  int  connect_results = 0;
  int  error_results   = 0;
  int  results_taken   = 0;
  int  in_stall_cycles = 0;
  int  quiet_cycles    = 0;

  bit  src_idle  = 1'b1;  // sender inserts random gaps
  bit  sink_idle = 1'b1;  // receiver inserts random stalls
  bit  zero_mix  = 1'b0;  // sprinkle ignored zero bytes into the text
  bit  hold_req  = 1'b0;  // ask the receiver for one long hold-off

  // ---------------------------------------------------------------------------
  // Recognizer prediction
  //
  // Keyword search is done on a window of the last seven collected bytes:
  // a keyword is seen once it ends the window. Since the found flags are
  // sticky until the collection empties, this gives the same flags as a
  // running prefix matcher.
  // ---------------------------------------------------------------------------
  afr_phase_t  phase;
  logic [8:0]  fill;        // bytes collected, saturates at BUF_DEPTH
  logic [7:0]  last_byte;   // last nonzero byte, survives an empty collection
  logic [55:0] recent;      // newest collected byte in [7:0]
  logic        saw_ok, saw_error, saw_fail, saw_connect;

  function automatic void empty_collection();
    fill        = '0;
    recent      = '0;
    saw_ok      = 1'b0;
    saw_error   = 1'b0;
    saw_fail    = 1'b0;
    saw_connect = 1'b0;
  endfunction

  function automatic void post_result(logic status, logic conn);
    afr_result_t r;
    r.status  = status;
    r.connect = conn;
    expected_results.push_back(r);
    if (status) error_results++;
    else ok_results++;
    if (conn) connect_results++;
    empty_collection();
    phase = PH_LEAD;
  endfunction

  function automatic void predict_byte(logic [7:0] b);
    logic [8:0] had;
    logic [7:0] prior;
    logic       crlf;
    if (b == 8'h00) return;
    prior     = last_byte;
    had       = fill;
    last_byte = b;
    // bytes past a full buffer drive framing only
    if (fill < BUF_DEPTH) begin
      recent      = {recent[47:0], b};
      saw_ok      |= (recent[15:0] == "OK");
      saw_error   |= (recent[39:0] == "ERROR");
      saw_fail    |= (recent[31:0] == "FAIL");
      saw_connect |= (recent[55:0] == "CONNECT");
      fill++;
    end
    crlf = (had != 0) && (prior == CH_CR) && (b == CH_LF);

    case (phase)
      PH_LINE: begin
        if (crlf) begin
          if (saw_ok) post_result(1'b0, saw_connect);
          else if (saw_error || saw_fail) post_result(1'b1, 1'b0);
          else phase = PH_INFO_CR;
        end
      end
      PH_INFO_CR: begin
        if (b == CH_CR) phase = PH_INFO_LF;
        else if (b == CH_O) phase = PH_FINAL;  // final line starts right away
        else post_result(1'b1, 1'b0);
      end
      PH_INFO_LF: begin
        if (b == CH_LF) phase = PH_FINAL;
        else post_result(1'b1, 1'b0);
      end
      PH_FINAL: begin
        if (crlf) post_result(!saw_ok, saw_ok && saw_connect);
      end
      default: begin
        phase = PH_LEAD;
        if (had == 0) begin
          // anything but CR as a first byte throws the collection away
          if (b != CH_CR) empty_collection();
        end else if (b == CH_LF) begin
          phase = PH_LINE;
        end else begin
          post_result(1'b1, 1'b0);
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Outputs are sampled at the edge, before the block's own updates land.
  always @(posedge clk) begin : result_check
    afr_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_taken++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none pending: status=%0b connect=%0b",
                                  final_status, connect_seen));
      end else begin
        want = expected_results.pop_front();
        if (final_status !== want.status)
          report_mismatch($sformatf("result %0d final_status got %b want %b",
                                    results_taken, final_status, want.status));
        if (connect_seen !== want.connect)
          report_mismatch($sformatf("result %0d connect_seen got %b want %b",
                                    results_taken, connect_seen, want.connect));
      end
    end
  end

  // Watchdog: the run is stuck if neither side completes a transfer for too long.
  always @(posedge clk) begin
    if (!rst && in_valid && in_stall) in_stall_cycles++;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
               $realtime, quiet_cycles, expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall before each result, plus one long hold-off on
  // request. out_stall gets at most one update per edge.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        gap = sink_idle ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        // out_valid seen here while out_stall was low means a transfer
        while (!out_valid && !hold_req) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  // One byte transfer; returns at the edge that accepts it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle ? $urandom_range(0, 13) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b == 8'h00) zeros_sent++;
    else bytes_sent++;
    predict_byte(b);
  endtask

  task automatic send_pending();
    while (pending_bytes.size() != 0) begin
      if (zero_mix && $urandom_range(0, 29) == 0) send_byte(8'h00);
      send_byte(pending_bytes.pop_front());
    end
  endtask

  // Sender goes quiet until every owed result has been taken.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void queue_text(input string s);
    for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
  endfunction

  function automatic void queue_crlf();
    pending_bytes.push_back(CH_CR);
    pending_bytes.push_back(CH_LF);
  endfunction

  function automatic void queue_line(input string s);
    queue_text(s);
    queue_crlf();
  endfunction

  function automatic void queue_fill(input int n, input logic [7:0] c);
    for (int i = 0; i < n; i++) pending_bytes.push_back(c);
  endfunction

  function automatic string pick_keyword();
    case ($urandom_range(0, 7))
      0: return "OK";
      1: return "ERROR";
      2: return "FAIL";
      3: return "CONNECT";
      4: return "CONN";
      5: return "ERRO";
      6: return "O";
      default: return "FAI";
    endcase
  endfunction

  // Mostly printable text, now and then a keyword or its fragment, rarely any byte.
  function automatic void queue_random_text(input int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: queue_text(pick_keyword());
        1: pending_bytes.push_back(8'($urandom_range(1, 255)));
        default: pending_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Final result on the first line.
  task automatic test_plain_results();
    queue_crlf(); queue_line("OK");
    queue_crlf(); queue_line("ERROR");
    queue_crlf(); queue_line("FAIL");
    send_pending();
    wait_drained();
  endtask

  // Info line, then final line either after a blank line or right away.
  task automatic test_info_lines();
    queue_crlf(); queue_line("CONNECT"); queue_crlf(); queue_line("OK");     // connect flag
    queue_crlf(); queue_line("AT");      queue_line("OK");                   // final starts with O
    queue_crlf(); queue_line("CONNECT"); queue_crlf(); queue_line("ERROR");  // no OK at the end
    queue_crlf(); queue_line("RING");    queue_crlf(); queue_line("BUSY");
    send_pending();
    wait_drained();
  endtask

  task automatic test_framing_errors();
    // non-CR first byte is dropped, the response after it still counts
    pending_bytes.push_back(8'hFF);
    queue_crlf(); queue_line("OK");
    // CR followed by something other than LF
    pending_bytes.push_back(CH_CR); pending_bytes.push_back(8'h80);
    // after an info line: neither CR nor O
    queue_crlf(); queue_line("AT"); pending_bytes.push_back(8'h01);
    // blank line broken by a non-LF byte
    queue_crlf(); queue_line("AT"); pending_bytes.push_back(CH_CR); pending_bytes.push_back(8'h7F);
    send_pending();
    wait_drained();
  endtask

  // Zero bytes are invisible, even between CR and LF.
  task automatic test_ignored_zeros();
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(CH_CR); pending_bytes.push_back(8'h00); pending_bytes.push_back(CH_LF);
    queue_text("O"); pending_bytes.push_back(8'h00); queue_text("K");
    pending_bytes.push_back(CH_CR); pending_bytes.push_back(8'h00); pending_bytes.push_back(CH_LF);
    send_pending();
    wait_drained();
  endtask

  // Keyword that ends exactly at the last searched byte, one that ends one
  // byte later, and plenty of bytes past the saturation point.
  task automatic test_buffer_saturation();
    src_idle = 1'b0;
    queue_crlf(); queue_fill(BUF_DEPTH - 4, "x"); queue_line("OK");        // OK found
    queue_crlf(); queue_fill(BUF_DEPTH - 3, "x"); queue_line("OK");        // K not searched
    queue_crlf(); queue_line("OK");                                        // not found at end
    queue_crlf(); queue_fill(BUF_DEPTH + 40, "y"); queue_line("ERROR");    // unsearched error
    queue_crlf(); queue_line("OK");
    queue_crlf(); queue_line("OK");                                        // count was cleared
    send_pending();
    src_idle = 1'b1;
    wait_drained();
  endtask

  // Receiver holds off while results pile up; the block must stall its input.
  task automatic test_output_backpressure();
    src_idle = 1'b0;
    hold_req = 1'b1;
    repeat (8) begin
      queue_crlf();
      queue_line("OK");
    end
    send_pending();
    src_idle = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int keep;
    zero_mix = 1'b1;
    while (bytes_sent < BYTE_TARGET) begin
      // stretches without idling on one side or both
      if ($urandom_range(0, 7) == 0) src_idle = $urandom_range(0, 2) != 0;
      if ($urandom_range(0, 7) == 0) sink_idle = $urandom_range(0, 2) != 0;
      case ($urandom_range(0, 12))
        0, 1: begin
          queue_crlf(); queue_line("OK");
        end
        2, 3: begin  // info line, blank line, final line
          queue_crlf(); queue_random_text($urandom_range(0, 12)); queue_crlf();
          queue_crlf();
          if ($urandom_range(0, 1)) queue_text("OK");
          else queue_random_text($urandom_range(0, 6));
          queue_crlf();
        end
        4: begin
          queue_crlf(); queue_text("CONNECT"); queue_random_text($urandom_range(0, 6));
          queue_crlf(); queue_crlf();
          if ($urandom_range(0, 3) != 0) queue_line("OK");
          else queue_line("ERROR");
        end
        5: begin  // final line right after an info line
          queue_crlf(); queue_random_text($urandom_range(1, 10)); queue_crlf();
          queue_text("O"); queue_random_text($urandom_range(0, 4)); queue_crlf();
        end
        6: begin
          queue_crlf(); queue_random_text($urandom_range(0, 5));
          if ($urandom_range(0, 1)) queue_text("ERROR");
          else queue_text("FAIL");
          queue_random_text($urandom_range(0, 5)); queue_crlf();
        end
        7, 8: begin  // raw noise over the whole byte range
          repeat ($urandom_range(1, 10)) pending_bytes.push_back(8'($urandom_range(0, 255)));
        end
        9: begin  // well-formed response cut short, then a stray byte
          queue_crlf(); queue_random_text($urandom_range(0, 6)); queue_crlf();
          queue_crlf(); queue_line("OK");
          keep = $urandom_range(1, pending_bytes.size() - 1);
          while (pending_bytes.size() > keep) pending_bytes.delete(pending_bytes.size() - 1);
          pending_bytes.push_back(8'($urandom_range(1, 255)));
        end
        10: begin  // junk before the leading CR
          repeat ($urandom_range(1, 3)) pending_bytes.push_back(8'($urandom_range(1, 255)));
          queue_crlf(); queue_line("OK");
        end
        11: begin  // rare long line that can run past the buffer
          queue_crlf();
          if ($urandom_range(0, 5) == 0) queue_random_text($urandom_range(240, 280));
          else queue_random_text($urandom_range(10, 40));
          queue_crlf(); queue_crlf(); queue_line("OK");
        end
        default: begin
          queue_crlf(); queue_line("OK");
          if ($urandom_range(0, 3) == 0) begin
            send_pending();
            wait_drained();
          end
        end
      endcase
      send_pending();
    end
    zero_mix  = 1'b0;
    src_idle  = 1'b1;
    sink_idle = 1'b1;
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    phase     = PH_LEAD;
    last_byte = 8'h00;
    empty_collection();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_plain_results();
    test_info_lines();
    test_framing_errors();
    test_ignored_zeros();
    test_buffer_saturation();
    test_output_backpressure();
    test_random_traffic();

    $display("Covered %0d bytes plus %0d ignored zeros, input stalled %0d cycles.",
             bytes_sent, zeros_sent, in_stall_cycles);
    $display("Results: %0d OK (%0d with CONNECT), %0d error, %0d mismatches.",
             ok_results, connect_results, error_results, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/afr_pkg.sv
src/afr_match_cell.sv
src/afr_frame_ctrl.sv
src/afr_out_queue.sv
src/at_final_result_recognizer.sv
tb/at_final_result_recognizer_tb.sv
